// ===== design/chroma_key_matte_despill_assert.svh =====
// ---------------------------------------------------------------------------
// Chroma key matte despill - assertion macros
// Shared property wrappers for the checker.
// ---------------------------------------------------------------------------
`ifndef CHROMA_KEY_MATTE_DESPILL_ASSERT_SVH
`define CHROMA_KEY_MATTE_DESPILL_ASSERT_SVH

// Same-cycle implication, off while reset is held.
`define CKMD_ASSERT_NOW(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("ckmd check failed");

// Next-cycle implication, off while reset is held.
`define CKMD_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("ckmd check failed");

// Next-cycle implication that also covers reset.
`define CKMD_ASSERT_NEXT_ALL(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("ckmd reset check failed");

`endif

// ===== design/ckmd_pkg.sv =====
// ---------------------------------------------------------------------------
// Chroma key matte despill - package
// Types, constants and divider step functions shared by the block.
// ---------------------------------------------------------------------------
`default_nettype none

package ckmd_pkg;

    localparam int unsigned QBits = 16;
    localparam logic [16:0] QOne  = 17'd65536;
    localparam logic [17:0] SpanEps = 18'd66;
    // ceil(2^35/25) and ceil(2^37/765): exact floor division over the used ranges
    localparam logic [30:0] Recip25  = 31'd1374389535;
    localparam logic [27:0] Recip765 = 28'd179658763;

    localparam logic [2:0] RegScreenRed   = 3'd0;
    localparam logic [2:0] RegScreenGreen = 3'd1;
    localparam logic [2:0] RegScreenBlue  = 3'd2;
    localparam logic [2:0] RegScreenGain  = 3'd3;
    localparam logic [2:0] RegClipBlack   = 3'd4;
    localparam logic [2:0] RegClipWhite   = 3'd5;
    localparam logic [2:0] RegDespillEn   = 3'd6;

    typedef struct packed {
        logic [7:0] screen_red;
        logic [7:0] screen_green;
        logic [7:0] screen_blue;
        logic [7:0] screen_gain;
        logic [7:0] clip_black;
        logic [7:0] clip_white;
        logic       despill_en;
    } t_cfg;

    typedef struct packed {
        logic [25:0] sg_red;
        logic [25:0] sg_green;
        logic [25:0] sg_blue;
        logic [16:0] cb;
        logic [16:0] span_abs;
        logic        span_neg;
    } t_derived;

    // spill divider: remainder plus a word that shifts dividend out, quotient in
    typedef struct packed {
        logic [7:0]  rem;
        logic [23:0] w;
    } t_sp;

    // matte divider: remainder and quotient
    typedef struct packed {
        logic [16:0] rem;
        logic [15:0] q;
    } t_md;

    function automatic t_sp sp_step(t_sp st, logic [7:0] dv);
        logic [8:0] r2;
        logic       ge;
        t_sp        res;
        r2      = {st.rem, st.w[23]};
        ge      = (r2 >= {1'b0, dv});
        r2      = ge ? (r2 - {1'b0, dv}) : r2;
        res.rem = r2[7:0];
        res.w   = {st.w[22:0], ge};
        return res;
    endfunction

    function automatic t_md md_step(t_md st, logic [16:0] b);
        logic [17:0] r2;
        logic        ge;
        t_md         res;
        r2      = {st.rem, 1'b0};
        ge      = (r2 >= {1'b0, b});
        r2      = ge ? (r2 - {1'b0, b}) : r2;
        res.rem = r2[16:0];
        res.q   = {st.q[14:0], ge};
        return res;
    endfunction

    // x*65536/255 floored: 65536 = 255*257 + 1
    function automatic logic [16:0] clip_level(logic [7:0] x);
        return 17'(x) * 17'd257 + ((x == 8'd255) ? 17'd1 : 17'd0);
    endfunction

endpackage

`default_nettype wire

// ===== design/ckmd_derive.sv =====
// ---------------------------------------------------------------------------
// Chroma key matte despill - configuration derived values
// Two register stages turning the settings into screen and clip terms.
// ---------------------------------------------------------------------------
`default_nettype none

module ckmd_derive (
    input  wire              i_clk,
    input  wire ckmd_pkg::t_cfg i_cfg,
    output ckmd_pkg::t_derived o_der
);

    logic [15:0] r_prod [3];
    logic [16:0] r_cb;
    logic [16:0] r_span_abs;
    logic        r_span_neg;
    logic [25:0] r_sg [3];
    logic [16:0] r_cb2;
    logic [16:0] r_span_abs2;
    logic        r_span_neg2;

    logic [16:0] n_cw;
    logic [16:0] n_cb;
    logic [17:0] n_span;
    logic [60:0] n_sgp [3];

    always_comb begin
        n_cb   = ckmd_pkg::clip_level(i_cfg.clip_black);
        n_cw   = ckmd_pkg::clip_level(i_cfg.clip_white);
        n_span = {1'b0, n_cw} - {1'b0, n_cb} + ckmd_pkg::SpanEps;
        for (int c = 0; c < 3; c++) begin
            n_sgp[c] = 61'({r_prod[c], 14'd0}) * 61'(ckmd_pkg::Recip25);
        end
    end

    // stage one: screen times gain, clip levels and span
    always_ff @(posedge i_clk) begin
        r_prod[0]  <= 16'(i_cfg.screen_red)   * 16'(i_cfg.screen_gain);
        r_prod[1]  <= 16'(i_cfg.screen_green) * 16'(i_cfg.screen_gain);
        r_prod[2]  <= 16'(i_cfg.screen_blue)  * 16'(i_cfg.screen_gain);
        r_cb       <= n_cb;
        r_span_neg <= n_span[17];
        r_span_abs <= n_span[17] ? 17'(-n_span) : n_span[16:0];
    end

    // stage two: scaled screen = prod*65536/100
    always_ff @(posedge i_clk) begin
        for (int c = 0; c < 3; c++) begin
            r_sg[c] <= n_sgp[c][60:35];
        end
        r_cb2       <= r_cb;
        r_span_abs2 <= r_span_abs;
        r_span_neg2 <= r_span_neg;
    end

    assign o_der.sg_red   = r_sg[0];
    assign o_der.sg_green = r_sg[1];
    assign o_der.sg_blue  = r_sg[2];
    assign o_der.cb       = r_cb2;
    assign o_der.span_abs = r_span_abs2;
    assign o_der.span_neg = r_span_neg2;

endmodule

`default_nettype wire

// ===== design/chroma_key_matte_despill.sv =====
// ---------------------------------------------------------------------------
// Chroma key matte despill - top level
// Difference matte against a screen colour, clip rescale and spill removal.
// ---------------------------------------------------------------------------
// Throughput: one pixel per cycle while the output accepts; ten pipeline stages, each with a valid bit.
// Stalls only back up as far as the first empty stage (bubbles collapse).
// Reset (synchronous, active low) empties the pipe and loads register defaults.
// Settings reach the derived screen and clip terms via the settings and derive registers.
`default_nettype none

module chroma_key_matte_despill (
    input  wire         i_clk,
    input  wire         i_rst_n,
    // settings write port
    input  wire         i_cfg_we,
    input  wire  [2:0]  i_cfg_index,
    input  wire  [7:0]  i_cfg_data,
    // pixel in
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire  [23:0] s_axis_tdata,  // pixel_red, pixel_green, pixel_blue
    // keyed pixel out
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [31:0] m_axis_tdata   // out_red, out_green, out_blue, out_alpha
);

    localparam int NStg = 10;

    // -----------------------------------------------------------------------
    // Settings registers
    // -----------------------------------------------------------------------
    ckmd_pkg::t_cfg     r_cfg;
    ckmd_pkg::t_derived der;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.screen_red   <= 8'd0;
            r_cfg.screen_green <= 8'd255;
            r_cfg.screen_blue  <= 8'd0;
            r_cfg.screen_gain  <= 8'd100;
            r_cfg.clip_black   <= 8'd0;
            r_cfg.clip_white   <= 8'd255;
            r_cfg.despill_en   <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                ckmd_pkg::RegScreenRed:   r_cfg.screen_red   <= i_cfg_data;
                ckmd_pkg::RegScreenGreen: r_cfg.screen_green <= i_cfg_data;
                ckmd_pkg::RegScreenBlue:  r_cfg.screen_blue  <= i_cfg_data;
                ckmd_pkg::RegScreenGain:  r_cfg.screen_gain  <= i_cfg_data;
                ckmd_pkg::RegClipBlack:   r_cfg.clip_black   <= i_cfg_data;
                ckmd_pkg::RegClipWhite:   r_cfg.clip_white   <= i_cfg_data;
                ckmd_pkg::RegDespillEn:   r_cfg.despill_en   <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    ckmd_derive u_derive (
        .i_clk (i_clk),
        .i_cfg (r_cfg),
        .o_der (der)
    );

    // -----------------------------------------------------------------------
    // Pipeline flow: a stage advances when it is empty or its successor moves
    // -----------------------------------------------------------------------
    logic [NStg-1:0] r_v;
    logic [NStg:0]   ce;

    always_comb begin
        ce[NStg] = m_axis_tready;
        for (int k = NStg - 1; k >= 0; k--) begin
            ce[k] = !r_v[k] || ce[k+1];
        end
    end

    assign s_axis_tready = ce[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (ce[0]) begin
                r_v[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NStg; k++) begin
                if (ce[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    // pixel channels travel alongside every stage
    logic [7:0] r_pix [NStg][3];

    always_ff @(posedge i_clk) begin
        if (ce[0]) begin
            r_pix[0][0] <= s_axis_tdata[7:0];
            r_pix[0][1] <= s_axis_tdata[15:8];
            r_pix[0][2] <= s_axis_tdata[23:16];
        end
        for (int k = 1; k < NStg; k++) begin
            if (ce[k]) begin
                r_pix[k] <= r_pix[k-1];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage 0 -> 1: pick the channel with the least pixel/screen ratio by
    // cross multiplication, then divide only that one.
    // -----------------------------------------------------------------------
    logic [7:0]  dv [3];
    logic [15:0] xp [3][3];
    logic        lt10, lt20, lt21;
    logic [1:0]  sel;
    logic        black;
    ckmd_pkg::t_sp n_sp1;

    always_comb begin
        dv[0] = (r_cfg.screen_red   == 8'd0) ? 8'd1 : r_cfg.screen_red;
        dv[1] = (r_cfg.screen_green == 8'd0) ? 8'd1 : r_cfg.screen_green;
        dv[2] = (r_cfg.screen_blue  == 8'd0) ? 8'd1 : r_cfg.screen_blue;
        for (int a = 0; a < 3; a++) begin
            for (int b = 0; b < 3; b++) begin
                xp[a][b] = 16'(r_pix[0][a]) * 16'(dv[b]);
            end
        end
        lt10 = xp[1][0] < xp[0][1];
        lt20 = xp[2][0] < xp[0][2];
        lt21 = xp[2][1] < xp[1][2];
        if (!lt10 && !lt20) begin
            sel = 2'd0;
        end else if (lt21) begin
            sel = 2'd2;
        end else begin
            sel = 2'd1;
        end
        black = (r_cfg.screen_red == 8'd0) && (r_cfg.screen_green == 8'd0)
                && (r_cfg.screen_blue == 8'd0);
        n_sp1.rem = 8'd0;
        n_sp1.w   = {r_pix[0][sel], 16'd0};
    end

    // spill divider state, stages 1 to 4 (eight quotient bits in each of stages 2 to 4)
    ckmd_pkg::t_sp r_sp       [1:4];
    logic [7:0]    r_sp_dv    [1:4];
    logic          r_sp_black [1:4];
    ckmd_pkg::t_sp n_sp       [2:4];

    always_comb begin
        for (int k = 2; k <= 4; k++) begin
            n_sp[k] = r_sp[k-1];
            for (int j = 0; j < 8; j++) begin
                n_sp[k] = ckmd_pkg::sp_step(n_sp[k], r_sp_dv[k-1]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[1]) begin
            r_sp[1]       <= n_sp1;
            r_sp_dv[1]    <= dv[sel];
            r_sp_black[1] <= black;
        end
        for (int k = 2; k <= 4; k++) begin
            if (ce[k]) begin
                r_sp[k]       <= n_sp[k];
                r_sp_dv[k]    <= r_sp_dv[k-1];
                r_sp_black[k] <= r_sp_black[k-1];
            end
        end
    end

    // -----------------------------------------------------------------------
    // Stage 1 -> 2: summed distance from the scaled screen colour
    // -----------------------------------------------------------------------
    logic [25:0] sg [3];
    logic [25:0] pq;
    logic [25:0] absd [3];
    logic [27:0] n_sum;
    logic [27:0] r2_sum;

    always_comb begin
        sg[0] = der.sg_red;
        sg[1] = der.sg_green;
        sg[2] = der.sg_blue;
        n_sum = '0;
        for (int c = 0; c < 3; c++) begin
            pq      = {2'b00, r_pix[1][c], 16'd0};
            absd[c] = (pq > sg[c]) ? (pq - sg[c]) : (sg[c] - pq);
            n_sum   = n_sum + 28'(absd[c]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[2]) begin
            r2_sum <= n_sum;
        end
    end

    // Stage 2 -> 3: distance / 765 by reciprocal
    logic [55:0] n_dprod;
    logic [18:0] r3_d;

    assign n_dprod = 56'(r2_sum) * 56'(ckmd_pkg::Recip765);

    always_ff @(posedge i_clk) begin
        if (ce[3]) begin
            r3_d <= n_dprod[55:37];
        end
    end

    // -----------------------------------------------------------------------
    // Stage 3 -> 4: raw matte, clip offset, and the signs that decide whether
    // the rescale division is zero, saturated or needs its 16 quotient bits.
    // -----------------------------------------------------------------------
    logic [16:0] dcl;
    logic [16:0] m0;
    logic [17:0] num;
    logic [16:0] num_abs;
    logic        n_zero, n_sat;
    ckmd_pkg::t_md n_md4;

    always_comb begin
        dcl     = (r3_d > 19'(ckmd_pkg::QOne)) ? ckmd_pkg::QOne : r3_d[16:0];
        m0      = ckmd_pkg::QOne - dcl;
        num     = {1'b0, m0} - {1'b0, der.cb};
        num_abs = num[17] ? 17'(-num) : num[16:0];
        n_zero  = (num == 18'd0) || (num[17] != der.span_neg);
        n_sat   = !n_zero && (num_abs >= der.span_abs);
        n_md4.rem = num_abs;
        n_md4.q   = '0;
    end

    ckmd_pkg::t_md r_md      [4:6];
    logic          r_md_zero [4:6];
    logic          r_md_sat  [4:6];
    ckmd_pkg::t_md n_md      [5:7];

    // six quotient bits, then five, then five
    always_comb begin
        n_md[5] = r_md[4];
        for (int j = 0; j < 6; j++) begin
            n_md[5] = ckmd_pkg::md_step(n_md[5], der.span_abs);
        end
        for (int k = 6; k <= 7; k++) begin
            n_md[k] = r_md[k-1];
            for (int j = 0; j < 5; j++) begin
                n_md[k] = ckmd_pkg::md_step(n_md[k], der.span_abs);
            end
        end
    end

    // spill ratio leaves its divider at stage 4 and rides along
    logic [23:0] r_s [5:7];

    always_ff @(posedge i_clk) begin
        if (ce[4]) begin
            r_md[4]      <= n_md4;
            r_md_zero[4] <= n_zero;
            r_md_sat[4]  <= n_sat;
        end
        for (int k = 5; k <= 6; k++) begin
            if (ce[k]) begin
                r_md[k]      <= n_md[k];
                r_md_zero[k] <= r_md_zero[k-1];
                r_md_sat[k]  <= r_md_sat[k-1];
            end
        end
        if (ce[5]) begin
            r_s[5] <= r_sp_black[4] ? 24'd0 : r_sp[4].w;
        end
        for (int k = 6; k <= 7; k++) begin
            if (ce[k]) begin
                r_s[k] <= r_s[k-1];
            end
        end
    end

    // Stage 6 -> 7: final matte
    logic [16:0] n_m;
    logic [16:0] r7_m;

    always_comb begin
        if (r_md_zero[6]) begin
            n_m = 17'd0;
        end else if (r_md_sat[6]) begin
            n_m = ckmd_pkg::QOne;
        end else begin
            n_m = {1'b0, n_md[7].q};
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[7]) begin
            r7_m <= n_m;
        end
    end

    // -----------------------------------------------------------------------
    // Stage 7 -> 8: spill amount (1-matte)*spill and alpha
    // -----------------------------------------------------------------------
    logic [16:0] om;
    logic [40:0] n_tprod;
    logic [24:0] n_alpha_p;
    logic [24:0] r8_t;
    logic [7:0]  r8_alpha;

    always_comb begin
        om        = ckmd_pkg::QOne - r7_m;
        n_tprod   = 41'(om) * 41'(r_s[7]);
        n_alpha_p = 25'(r7_m) * 25'd255;
    end

    always_ff @(posedge i_clk) begin
        if (ce[8]) begin
            r8_t     <= n_tprod[40:16];
            r8_alpha <= n_alpha_p[23:16];
        end
    end

    // -----------------------------------------------------------------------
    // Stage 8 -> 9: despill factor and channel scaling into the output
    // register. The factor never exceeds one, so only the low clamp matters.
    // -----------------------------------------------------------------------
    logic [25:0] fac;
    logic [24:0] chp [3];
    logic [7:0]  n_out [3];
    logic [7:0]  r9_out [3];
    logic [7:0]  r9_alpha;

    always_comb begin
        fac = 26'(ckmd_pkg::QOne) - {1'b0, r8_t};
        for (int c = 0; c < 3; c++) begin
            chp[c] = 25'(r_pix[8][c]) * 25'(fac[16:0]);
            if (!r_cfg.despill_en) begin
                n_out[c] = r_pix[8][c];
            end else if (fac[25] || fac == 26'd0) begin
                n_out[c] = 8'd0;
            end else begin
                n_out[c] = chp[c][23:16];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (ce[9]) begin
            r9_out   <= n_out;
            r9_alpha <= r8_alpha;
        end
    end

    assign m_axis_tvalid = r_v[NStg-1];
    assign m_axis_tdata  = {r9_alpha, r9_out[2], r9_out[1], r9_out[0]};

endmodule

`default_nettype wire

// ===== design/ckmd_checker.sv =====
// ---------------------------------------------------------------------------
// Chroma key matte despill - port checker
// Watches the top-level ports and is bound to every instance.
// ---------------------------------------------------------------------------
`default_nettype none

`include "chroma_key_matte_despill_assert.svh"

module ckmd_checker (
    input wire        i_clk,
    input wire        i_rst_n,
    input wire        s_axis_tvalid,
    input wire        s_axis_tready,
    input wire        m_axis_tvalid,
    input wire        m_axis_tready,
    input wire [31:0] m_axis_tdata
);

    // a result held back keeps its value
    `CKMD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata))

    // an empty output stage means the whole pipe can take a pixel
    `CKMD_ASSERT_NOW(a_ready_when_empty, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready)

    // reset flushes the pipe
    `CKMD_ASSERT_NEXT_ALL(a_reset_flush, i_clk, !i_rst_n, !m_axis_tvalid)

    // with the output empty and no pixel offered, now and at the check before,
    // a result that then shows up must come with the input ready
    `CKMD_ASSERT_NEXT(a_no_spurious, i_clk, i_rst_n, !m_axis_tvalid && !s_axis_tvalid && $past(!m_axis_tvalid && !s_axis_tvalid), !m_axis_tvalid || s_axis_tready)

endmodule

bind chroma_key_matte_despill ckmd_checker u_ckmd_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

`default_nettype wire
